// ===== design/xzr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xzr_pkg : shared types and constants for the zigzag polyphase resampler
// Sample widths, history ring geometry, the 7-phase by 29-tap coefficient
// table and the command structures passed to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package xzr_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int HISTORY_DEPTH = 32;
   localparam int TAP_COUNT     = 29;
   localparam int PHASE_COUNT   = 7;
   localparam int SIX_STEPS     = 6;

   localparam int PTR_W   = $clog2(HISTORY_DEPTH);
   localparam int TAP_W   = $clog2(TAP_COUNT);
   localparam int PHASE_W = $clog2(PHASE_COUNT);
   localparam int SIX_W   = $clog2(SIX_STEPS + 1);

   // product, arithmetic shift and accumulator sizing
   localparam int PROD_W  = 2 * SAMPLE_W;
   localparam int SHIFT   = 15;
   localparam int TERM_W  = PROD_W - SHIFT;
   localparam int ACC_W   = TERM_W + $clog2(TAP_COUNT);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RUN,
      S_DRAIN,
      S_LOAD,
      S_SEND
   } seq_state_type;

   // one tap of one channel issued to the MAC unit
   typedef struct packed {
      logic               valid;
      logic               chan;   // 0 left, 1 right
      logic               first;  // tap zero: restart the accumulator
      logic [PHASE_W-1:0] phase;
      logic [TAP_W-1:0]   tap;
   } mac_cmd_type;

   // control carried down the MAC pipeline
   typedef struct packed {
      logic valid;
      logic chan;
      logic first;
   } mac_stage_type;

   localparam logic signed [SAMPLE_W-1:0] COEF_TABLE [PHASE_COUNT][TAP_COUNT] = '{
      '{ 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, -16'sh0002, 16'sh000A,
        -16'sh0022, 16'sh0041, -16'sh0054, 16'sh0034, 16'sh0009, -16'sh010A, 16'sh0400,
        -16'sh0A78, 16'sh234C, 16'sh6794, -16'sh1780, 16'sh0BCD, -16'sh0623, 16'sh0350,
        -16'sh016D, 16'sh006B, 16'sh000A, -16'sh0010, 16'sh0011, -16'sh0008, 16'sh0003,
        -16'sh0001 },
      '{ 16'sh0000, 16'sh0000, 16'sh0000, -16'sh0002, 16'sh0000, 16'sh0003, -16'sh0013,
         16'sh003C, -16'sh004B, 16'sh00A2, -16'sh00E3, 16'sh0132, -16'sh0043, -16'sh0267,
         16'sh0C9D, 16'sh74BB, -16'sh11B4, 16'sh09B8, -16'sh05BF, 16'sh0372, -16'sh01A8,
         16'sh00A6, -16'sh001B, 16'sh0005, 16'sh0006, -16'sh0008, 16'sh0003, -16'sh0001,
         16'sh0000 },
      '{ 16'sh0000, 16'sh0000, -16'sh0001, 16'sh0003, -16'sh0002, -16'sh0005, 16'sh001F,
        -16'sh004A, 16'sh00B3, -16'sh0192, 16'sh02B1, -16'sh039E, 16'sh04F8, -16'sh05A6,
         16'sh7939, -16'sh05A6, 16'sh04F8, -16'sh039E, 16'sh02B1, -16'sh0192, 16'sh00B3,
        -16'sh004A, 16'sh001F, -16'sh0005, -16'sh0002, 16'sh0003, -16'sh0001, 16'sh0000,
         16'sh0000 },
      '{ 16'sh0000, -16'sh0001, 16'sh0003, -16'sh0008, 16'sh0006, 16'sh0005, -16'sh001B,
         16'sh00A6, -16'sh01A8, 16'sh0372, -16'sh05BF, 16'sh09B8, -16'sh11B4, 16'sh74BB,
         16'sh0C9D, -16'sh0267, -16'sh0043, 16'sh0132, -16'sh00E3, 16'sh00A2, -16'sh004B,
         16'sh003C, -16'sh0013, 16'sh0003, 16'sh0000, -16'sh0002, 16'sh0000, 16'sh0000,
         16'sh0000 },
      '{-16'sh0001, 16'sh0003, -16'sh0008, 16'sh0011, -16'sh0010, 16'sh000A, 16'sh006B,
        -16'sh016D, 16'sh0350, -16'sh0623, 16'sh0BCD, -16'sh1780, 16'sh6794, 16'sh234C,
        -16'sh0A78, 16'sh0400, -16'sh010A, 16'sh0009, 16'sh0034, -16'sh0054, 16'sh0041,
        -16'sh0022, 16'sh000A, -16'sh0001, 16'sh0000, 16'sh0001, 16'sh0000, 16'sh0000,
         16'sh0000 },
      '{ 16'sh0002, -16'sh0008, 16'sh0010, -16'sh0023, 16'sh002B, 16'sh001A, -16'sh00EB,
         16'sh027B, -16'sh0548, 16'sh0AFA, -16'sh16FA, 16'sh53E0, 16'sh3C07, -16'sh1249,
         16'sh080E, -16'sh0347, 16'sh015B, -16'sh0044, -16'sh0017, 16'sh0046, -16'sh0023,
         16'sh0011, -16'sh0005, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
         16'sh0000 },
      '{-16'sh0005, 16'sh0011, -16'sh0023, 16'sh0046, -16'sh0017, -16'sh0044, 16'sh015B,
        -16'sh0347, 16'sh080E, -16'sh1249, 16'sh3C07, 16'sh53E0, -16'sh16FA, 16'sh0AFA,
        -16'sh0548, 16'sh027B, -16'sh00EB, 16'sh001A, 16'sh002B, -16'sh0023, 16'sh0010,
        -16'sh0008, 16'sh0002, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
         16'sh0000 }
   };

endpackage

// ===== design/xzr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xzr_if : stream interfaces of the zigzag polyphase resampler
// Input pair channel and filtered output pair channel, valid/ready each.
// ----------------------------------------------------------------------------
interface xzr_req_if;
   import xzr_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_sample;
   logic signed [SAMPLE_W-1:0] right_sample;

   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface xzr_rsp_if;
   import xzr_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_out;
   logic signed [SAMPLE_W-1:0] right_out;
   logic                       last_of_burst;

   modport source (output valid, output left_out, output right_out,
                   output last_of_burst, input ready);
   modport sink   (input valid, input left_out, input right_out,
                   input last_of_burst, output ready);
endinterface

// ===== design/xa_zigzag_polyphase_resampler.sv =====
`timescale 1ns / 1ps
// An input that does not complete a group of six is accepted and leaves the block ready.
// Every sixth input starts a burst: each output pair is summed on the shared
// multiplier for 29 taps x 2 channels, then drained, loaded and handed over,
// and a burst is 7 pairs or 14 pairs, as the rate mode selects.
// req.ready is low from burst start until the last pair has been taken.
// Reset (synchronous, active high) empties the history, clears pointer and mode and sets the counter to six.
// ----------------------------------------------------------------------------
// xa_zigzag_polyphase_resampler : stereo 29-tap 7-phase resampler
// Pushes each input pair into a 32-entry history ring and, on every sixth
// pair, runs the FIR over all phases through one shared MAC unit.
// ----------------------------------------------------------------------------
module xa_zigzag_polyphase_resampler (
   input  logic       clock,
   input  logic       reset,
   xzr_req_if.sink    req,
   xzr_rsp_if.source  rsp,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import xzr_pkg::*;

   seq_state_type       state_ff, state_in;
   logic [TAP_W-1:0]    tap_ff, tap_in;
   logic                chan_ff, chan_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic                pass_ff, pass_in;
   logic                drain_ff, drain_in;
   logic [PTR_W-1:0]    wp_ff, wp_in;
   logic [SIX_W-1:0]    six_ff, six_in;
   logic                rate_mode_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_W-1:0] rsp_right_ff, rsp_right_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [2*SAMPLE_W-1:0] hist_mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] hist_valid_ff;
   logic [2*SAMPLE_W-1:0] rd_ff;
   logic                  rd_ok_ff;
   logic                  mem_we;
   logic [PTR_W:0]        addr_sum;
   logic [PTR_W-1:0]      rd_addr;
   logic [PTR_W-1:0]      wp_next;

   mac_cmd_type                cmd;
   logic signed [SAMPLE_W-1:0] hist_left, hist_right;
   logic signed [SAMPLE_W-1:0] sat_left, sat_right;
   logic                       accept;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         rate_mode_ff <= csr_wr_data;
      end
   end

   // ring addressing: tap i reads (pointer after push - i) mod depth
   always_comb begin
      addr_sum = {1'b0, wp_ff} + (PTR_W+1)'(HISTORY_DEPTH) - (PTR_W+1)'(tap_ff);
      if (addr_sum >= (PTR_W+1)'(HISTORY_DEPTH)) begin
         rd_addr = PTR_W'(addr_sum - (PTR_W+1)'(HISTORY_DEPTH));
      end else begin
         rd_addr = PTR_W'(addr_sum);
      end
      wp_next = (wp_ff == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   end

   // history ring, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[wp_ff] <= {req.left_sample, req.right_sample};
      end
      rd_ff <= hist_mem[rd_addr];
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_valid_ff <= '0;
         rd_ok_ff      <= 1'b0;
      end else begin
         if (mem_we) begin
            hist_valid_ff[wp_ff] <= 1'b1;
         end
         rd_ok_ff <= hist_valid_ff[rd_addr];
      end
   end

   assign hist_left  = rd_ok_ff ? rd_ff[2*SAMPLE_W-1:SAMPLE_W] : '0;
   assign hist_right = rd_ok_ff ? rd_ff[SAMPLE_W-1:0] : '0;

   xzr_mac_unit u_mac (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .hist_left  (hist_left),
      .hist_right (hist_right),
      .sat_left   (sat_left),
      .sat_right  (sat_right)
   );

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tap_ff       <= '0;
         chan_ff      <= 1'b0;
         phase_ff     <= '0;
         pass_ff      <= 1'b0;
         drain_ff     <= 1'b0;
         wp_ff        <= '0;
         six_ff       <= SIX_W'(SIX_STEPS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         chan_ff      <= chan_in;
         phase_ff     <= phase_in;
         pass_ff      <= pass_in;
         drain_ff     <= drain_in;
         wp_ff        <= wp_in;
         six_ff       <= six_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // next state: push, tap sweep, drain, load, hand over
   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      chan_in      = chan_ff;
      phase_in     = phase_ff;
      pass_in      = pass_ff;
      drain_in     = drain_ff;
      wp_in        = wp_ff;
      six_in       = six_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      cmd          = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mem_we = 1'b1;
               wp_in  = wp_next;
               if (six_ff > SIX_W'(1)) begin
                  six_in = six_ff - 1'b1;
               end else begin
                  six_in   = SIX_W'(SIX_STEPS);
                  state_in = S_RUN;
                  tap_in   = '0;
                  chan_in  = 1'b0;
                  phase_in = '0;
                  pass_in  = 1'b0;
               end
            end
         end
         S_RUN: begin
            cmd.valid = 1'b1;
            cmd.chan  = chan_ff;
            cmd.first = (tap_ff == '0);
            cmd.phase = phase_ff;
            cmd.tap   = tap_ff;
            if (chan_ff) begin
               chan_in = 1'b0;
               if (tap_ff == TAP_W'(TAP_COUNT - 1)) begin
                  state_in = S_DRAIN;
                  drain_in = 1'b0;
               end else begin
                  tap_in = tap_ff + 1'b1;
               end
            end else begin
               chan_in = 1'b1;
            end
         end
         S_DRAIN: begin
            // wait, counted by drain_ff, for the last taps to reach the accumulators
            if (drain_ff) begin
               state_in = S_LOAD;
            end else begin
               drain_in = 1'b1;
            end
         end
         S_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_left_in  = sat_left;
            rsp_right_in = sat_right;
            rsp_last_in  = (phase_ff == PHASE_W'(PHASE_COUNT - 1)) &&
                           (pass_ff == rate_mode_ff);
            state_in     = S_SEND;
         end
         S_SEND: begin
            if (rsp.ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_RUN;
                  tap_in   = '0;
                  chan_in  = 1'b0;
                  if (phase_ff == PHASE_W'(PHASE_COUNT - 1)) begin
                     phase_in = '0;
                     pass_in  = 1'b1;
                  end else begin
                     phase_in = phase_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.left_out      = rsp_left_ff;
   assign rsp.right_out     = rsp_right_ff;
   assign rsp.last_of_burst = rsp_last_ff;

   // no input is taken while a result is on offer
   a_no_accept_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("input ready while result pending");

   // a push that does not close a group of six leaves the block ready
   a_plain_push_ready: assert property (@(posedge clock) disable iff (reset)
      (accept && six_ff > SIX_W'(1)) |=> req.ready)
      else $error("ready dropped after plain push");

   // the sixth push starts a burst
   a_burst_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && six_ff == SIX_W'(1)) |=> (!req.ready && six_ff == SIX_W'(SIX_STEPS)))
      else $error("burst did not start");

   // the final pair of a burst returns the block to idle
   a_last_frees_input: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.last_of_burst) |=> req.ready)
      else $error("block not idle after last pair");

   // the step counter stays in range
   a_six_range: assert property (@(posedge clock) disable iff (reset)
      (six_ff >= SIX_W'(1)) && (six_ff <= SIX_W'(SIX_STEPS)))
      else $error("step counter out of range");

endmodule

// ===== design/xzr_mac_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xzr_mac_unit : shared multiply-accumulate for the FIR taps
// One signed 16x16 multiplier used for every tap of both channels. Three
// stages: coefficient lookup, multiply, shift-and-accumulate. Saturated
// accumulator values are offered to the sequencer.
// ----------------------------------------------------------------------------
module xzr_mac_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  xzr_pkg::mac_cmd_type                cmd,
   input  logic signed [xzr_pkg::SAMPLE_W-1:0] hist_left,
   input  logic signed [xzr_pkg::SAMPLE_W-1:0] hist_right,
   output logic signed [xzr_pkg::SAMPLE_W-1:0] sat_left,
   output logic signed [xzr_pkg::SAMPLE_W-1:0] sat_right
);
   import xzr_pkg::*;

   mac_stage_type              s1_ff, s2_ff;
   logic signed [SAMPLE_W-1:0] coef_ff;
   logic signed [SAMPLE_W-1:0] operand;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_left_ff, acc_right_ff;
   logic signed [ACC_W-1:0]    acc_base, acc_in;
   logic signed [ACC_W-1:0]    term;

   // stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
      end else begin
         s1_ff <= '{valid: cmd.valid, chan: cmd.chan, first: cmd.first};
         s2_ff <= s1_ff;
      end
   end

   // coefficient lookup, registered beside the history read
   always_ff @(posedge clock) begin
      coef_ff <= COEF_TABLE[cmd.phase][cmd.tap];
   end

   // multiply
   assign operand = s1_ff.chan ? hist_right : hist_left;
   assign prod_in = operand * coef_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // shift right by 15 (floor), then accumulate into the selected channel
   assign term     = {{(ACC_W-TERM_W){prod_ff[PROD_W-1]}}, prod_ff[PROD_W-1:SHIFT]};
   assign acc_base = s2_ff.first ? '0 : (s2_ff.chan ? acc_right_ff : acc_left_ff);
   assign acc_in   = acc_base + term;

   always_ff @(posedge clock) begin
      if (s2_ff.valid) begin
         if (s2_ff.chan) begin
            acc_right_ff <= acc_in;
         end else begin
            acc_left_ff <= acc_in;
         end
      end
   end

   // clamp to 16 bits: upper bits must all match the sign
   function automatic logic signed [SAMPLE_W-1:0] clamp16(input logic signed [ACC_W-1:0] a);
      logic [ACC_W-SAMPLE_W:0] top;
      begin
         top = a[ACC_W-1:SAMPLE_W-1];
         if (top == '0 || top == '1) begin
            clamp16 = a[SAMPLE_W-1:0];
         end else if (a[ACC_W-1]) begin
            clamp16 = {1'b1, {(SAMPLE_W-1){1'b0}}};
         end else begin
            clamp16 = {1'b0, {(SAMPLE_W-1){1'b1}}};
         end
      end
   endfunction

   assign sat_left  = clamp16(acc_left_ff);
   assign sat_right = clamp16(acc_right_ff);

endmodule

// ===== test/xa_zigzag_polyphase_resampler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xa_zigzag_polyphase_resampler_tb : self-checking bench for the resampler
// Drives stereo pairs through the request channel and checks every filtered
// pair against a behavioural 29-tap, 7-phase model held in the bench. A short
// table of directed rows comes first, then random phases at both rates, with
// random gaps on both channels and one long hold-off on the output side.
// ----------------------------------------------------------------------------
module xa_zigzag_polyphase_resampler_tb;
   import xzr_pkg::*;

   localparam int CLK_HALF      = 2;
   localparam int RESET_CYCLES  = 8;
   localparam int MAX_GAP       = 13;
   localparam int IDLE_SETTLE   = 8;
   localparam int DRAIN_CYCLES  = 1000;    // longer than an unstalled half-rate burst
   localparam int RX_HOLD       = 3000;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RAND_PHASES   = 4;
   localparam int PHASE_ITEMS   = 24;
   localparam int PRINT_CAP     = 40;

   localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

   // filter weights, one row per phase; tap 0 reads the ring slot just after
   // the newest sample, i.e. the oldest entry
   localparam int TAP_WEIGHTS [PHASE_COUNT][TAP_COUNT] = '{
      '{ 0, 0, 0, 0, 0, -'sh0002, 'sh000A, -'sh0022, 'sh0041, -'sh0054,
         'sh0034, 'sh0009, -'sh010A, 'sh0400, -'sh0A78, 'sh234C, 'sh6794, -'sh1780,
         'sh0BCD, -'sh0623, 'sh0350, -'sh016D, 'sh006B, 'sh000A, -'sh0010, 'sh0011,
         -'sh0008, 'sh0003, -'sh0001 },
      '{ 0, 0, 0, -'sh0002, 0, 'sh0003, -'sh0013, 'sh003C, -'sh004B, 'sh00A2,
         -'sh00E3, 'sh0132, -'sh0043, -'sh0267, 'sh0C9D, 'sh74BB, -'sh11B4, 'sh09B8,
         -'sh05BF, 'sh0372, -'sh01A8, 'sh00A6, -'sh001B, 'sh0005, 'sh0006, -'sh0008,
         'sh0003, -'sh0001, 0 },
      '{ 0, 0, -'sh0001, 'sh0003, -'sh0002, -'sh0005, 'sh001F, -'sh004A, 'sh00B3,
         -'sh0192, 'sh02B1, -'sh039E, 'sh04F8, -'sh05A6, 'sh7939, -'sh05A6, 'sh04F8,
         -'sh039E, 'sh02B1, -'sh0192, 'sh00B3, -'sh004A, 'sh001F, -'sh0005, -'sh0002,
         'sh0003, -'sh0001, 0, 0 },
      '{ 0, -'sh0001, 'sh0003, -'sh0008, 'sh0006, 'sh0005, -'sh001B, 'sh00A6,
         -'sh01A8, 'sh0372, -'sh05BF, 'sh09B8, -'sh11B4, 'sh74BB, 'sh0C9D, -'sh0267,
         -'sh0043, 'sh0132, -'sh00E3, 'sh00A2, -'sh004B, 'sh003C, -'sh0013, 'sh0003,
         0, -'sh0002, 0, 0, 0 },
      '{ -'sh0001, 'sh0003, -'sh0008, 'sh0011, -'sh0010, 'sh000A, 'sh006B, -'sh016D,
         'sh0350, -'sh0623, 'sh0BCD, -'sh1780, 'sh6794, 'sh234C, -'sh0A78, 'sh0400,
         -'sh010A, 'sh0009, 'sh0034, -'sh0054, 'sh0041, -'sh0022, 'sh000A, -'sh0001,
         0, 'sh0001, 0, 0, 0 },
      '{ 'sh0002, -'sh0008, 'sh0010, -'sh0023, 'sh002B, 'sh001A, -'sh00EB, 'sh027B,
         -'sh0548, 'sh0AFA, -'sh16FA, 'sh53E0, 'sh3C07, -'sh1249, 'sh080E, -'sh0347,
         'sh015B, -'sh0044, -'sh0017, 'sh0046, -'sh0023, 'sh0011, -'sh0005,
         0, 0, 0, 0, 0, 0 },
      '{ -'sh0005, 'sh0011, -'sh0023, 'sh0046, -'sh0017, -'sh0044, 'sh015B, -'sh0347,
         'sh080E, -'sh1249, 'sh3C07, 'sh53E0, -'sh16FA, 'sh0AFA, -'sh0548, 'sh027B,
         -'sh00EB, 'sh001A, 'sh002B, -'sh0023, 'sh0010, -'sh0008, 'sh0002,
         0, 0, 0, 0, 0, 0 }
   };

   // directed rows: a plain pair, a pair whose burst output is written in by
   // hand, or a rate mode write (mode in bit 0 of the left field)
   typedef enum logic [1:0] {
      ROW_PAIR,
      ROW_PINNED,
      ROW_MODE
   } row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic signed [SAMPLE_W-1:0] pin_left;
      logic signed [SAMPLE_W-1:0] pin_right;
   } row_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       last_flag;
   } out_pair_type;

   localparam row_type DIRECTED_ROWS [25] = '{
      // silence after reset: a normal-rate burst of zero pairs
      '{ROW_PINNED, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
      '{ROW_PINNED, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
      '{ROW_PINNED, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
      '{ROW_PINNED, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
      '{ROW_PINNED, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
      '{ROW_PINNED, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
      // field extremes and the smallest magnitudes of either sign
      '{ROW_PAIR,   16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000},
      '{ROW_PAIR,   16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000},
      '{ROW_PAIR,   16'sh7FFF, 16'sh7FFF, 16'sh0000, 16'sh0000},
      '{ROW_PAIR,   16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000},
      '{ROW_PAIR,   16'sh0001, 16'shFFFF, 16'sh0000, 16'sh0000},
      '{ROW_PAIR,   16'shFFFF, 16'sh0001, 16'sh0000, 16'sh0000},
      // half rate, then full-scale alternation to drive the sum into clamping
      '{ROW_MODE,   16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000},
      '{ROW_PAIR,   16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000},
      '{ROW_PAIR,   16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000},
      '{ROW_PAIR,   16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000},
      '{ROW_PAIR,   16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000},
      '{ROW_PAIR,   16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000},
      '{ROW_PAIR,   16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000},
      '{ROW_PAIR,   16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000},
      '{ROW_PAIR,   16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000},
      '{ROW_PAIR,   16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000},
      '{ROW_PAIR,   16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000},
      '{ROW_PAIR,   16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000},
      '{ROW_PAIR,   16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic csr_wr_data;

   xzr_req_if req_if ();
   xzr_rsp_if rsp_if ();

   xa_zigzag_polyphase_resampler i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if.sink),
      .rsp         (rsp_if.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // bench copy of the block state
   logic signed [SAMPLE_W-1:0] ring_left  [HISTORY_DEPTH];
   logic signed [SAMPLE_W-1:0] ring_right [HISTORY_DEPTH];
   int                         ring_wr;
   int                         burst_countdown;
   bit                         mode_shadow;
   out_pair_type               burst_pairs_due [$];

   // pinned output travels with the offered pair, so it is sampled alongside it
   logic                       pin_on;
   logic signed [SAMPLE_W-1:0] pin_left;
   logic signed [SAMPLE_W-1:0] pin_right;

   bit tx_quiet;
   bit rx_quiet;
   bit rx_hold_req;

   int cycle_count;
   int error_count;
   int pairs_in;
   int pairs_out;
   int bursts_normal;
   int bursts_half;
   int clamped_samples;

   // clock
   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   // run time guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pairs still due", cycle_count,
                  burst_pairs_due.size());
         $display("FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < PRINT_CAP)
         $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // one channel of one phase: floor-shifted products, summed and clamped
   function automatic logic signed [SAMPLE_W-1:0] fir_phase(input bit right_chan,
                                                            input int phase);
      int acc;
      int idx;
      int prod;
      acc = 0;
      for (int tap = 0; tap < TAP_COUNT; tap++) begin
         idx  = (ring_wr + HISTORY_DEPTH - tap) % HISTORY_DEPTH;
         prod = (right_chan ? int'(ring_right[idx]) : int'(ring_left[idx]))
                * TAP_WEIGHTS[phase][tap];
         acc += prod >>> 15;
      end
      if (acc > 32767 || acc < -32768)
         clamped_samples++;
      if (acc > 32767)
         acc = 32767;
      if (acc < -32768)
         acc = -32768;
      return acc[SAMPLE_W-1:0];
   endfunction

   // push one accepted pair, queue its burst when the group of six completes
   function automatic void resample_step(input logic signed [SAMPLE_W-1:0] l,
                                         input logic signed [SAMPLE_W-1:0] r,
                                         input logic pinned,
                                         input logic signed [SAMPLE_W-1:0] pl,
                                         input logic signed [SAMPLE_W-1:0] pr);
      out_pair_type op;
      int           burst_len;
      ring_left[ring_wr]  = l;
      ring_right[ring_wr] = r;
      ring_wr             = (ring_wr + 1) % HISTORY_DEPTH;
      pairs_in++;
      if (burst_countdown > 1) begin
         burst_countdown--;
         return;
      end
      burst_countdown = SIX_STEPS;
      burst_len       = mode_shadow ? 2 * PHASE_COUNT : PHASE_COUNT;
      if (mode_shadow)
         bursts_half++;
      else
         bursts_normal++;
      for (int j = 0; j < burst_len; j++) begin
         op.left      = fir_phase(1'b0, j % PHASE_COUNT);
         op.right     = fir_phase(1'b1, j % PHASE_COUNT);
         op.last_flag = (j == burst_len - 1);
         if (pinned) begin
            op.left  = pl;
            op.right = pr;
         end
         burst_pairs_due.push_back(op);
      end
   endfunction

   task automatic check_pair();
      out_pair_type want;
      if (burst_pairs_due.size() == 0) begin
         report_mismatch("unexpected pair, left", int'(rsp_if.left_out), 0);
         return;
      end
      want = burst_pairs_due.pop_front();
      pairs_out++;
      if (rsp_if.left_out !== want.left)
         report_mismatch("left_out", int'(rsp_if.left_out), int'(want.left));
      if (rsp_if.right_out !== want.right)
         report_mismatch("right_out", int'(rsp_if.right_out), int'(want.right));
      if (rsp_if.last_of_burst !== want.last_flag)
         report_mismatch("last_of_burst", int'(rsp_if.last_of_burst),
                         int'(want.last_flag));
   endtask

   // transaction monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            resample_step(req_if.left_sample, req_if.right_sample, pin_on, pin_left,
                          pin_right);
         if (rsp_if.valid && rsp_if.ready)
            check_pair();
      end
   end

   // output side: random hold-offs, one long stall on request
   initial begin
      int gap;
      rsp_if.ready = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (RX_HOLD) @(posedge clock);
         end
         gap = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid && !rx_hold_req);
      end
   end

   task automatic offer_pair(input logic signed [SAMPLE_W-1:0] l,
                             input logic signed [SAMPLE_W-1:0] r,
                             input logic pinned,
                             input logic signed [SAMPLE_W-1:0] pl,
                             input logic signed [SAMPLE_W-1:0] pr);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.left_sample  <= l;
      req_if.right_sample <= r;
      pin_on              <= pinned;
      pin_left            <= pl;
      pin_right           <= pr;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // quiet the input and wait for every due pair plus the short input latency
   task automatic settle_idle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (burst_pairs_due.size() != 0);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_rate_mode(input bit mode);
      settle_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      mode_shadow = mode;
   endtask

   // full-range values half the time, else extremes, small levels and underrun zeros
   function automatic logic signed [SAMPLE_W-1:0] draw_sample();
      logic [SAMPLE_W-1:0] raw;
      raw = SAMPLE_W'($urandom);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return S_MAX;
         2: return S_MIN;
         3: return $urandom_range(0, 1) ? SAMPLE_W'($urandom_range(0, 255))
                                        : -SAMPLE_W'($urandom_range(0, 255));
         default: return raw;
      endcase
   endfunction

   // stimulus
   initial begin
      row_type                    row;
      logic signed [SAMPLE_W-1:0] l;
      logic signed [SAMPLE_W-1:0] r;
      req_if.valid        = 1'b0;
      req_if.left_sample  = '0;
      req_if.right_sample = '0;
      csr_wr_en           = 1'b0;
      csr_wr_data         = 1'b0;
      pin_on              = 1'b0;
      pin_left            = '0;
      pin_right           = '0;
      tx_quiet            = 1'b0;
      rx_quiet            = 1'b0;
      rx_hold_req         = 1'b0;
      cycle_count         = 0;
      error_count         = 0;
      pairs_in            = 0;
      pairs_out           = 0;
      bursts_normal       = 0;
      bursts_half         = 0;
      clamped_samples     = 0;
      foreach (ring_left[k]) begin
         ring_left[k]  = '0;
         ring_right[k] = '0;
      end
      ring_wr         = 0;
      burst_countdown = SIX_STEPS;
      mode_shadow     = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (DIRECTED_ROWS[n]) begin
         row = DIRECTED_ROWS[n];
         case (row.kind)
            ROW_MODE: begin
               write_rate_mode(row.left[0]);
            end
            ROW_PINNED: begin
               offer_pair(row.left, row.right, 1'b1, row.pin_left, row.pin_right);
            end
            default: begin
               offer_pair(row.left, row.right, 1'b0, '0, '0);
            end
         endcase
      end

      // random phases: rate alternates, one phase under a long output stall,
      // the last one with no gaps on either side
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         write_rate_mode(ph[0]);
         tx_quiet = (ph == RAND_PHASES - 1);
         rx_quiet = (ph == RAND_PHASES - 1);
         if (ph == 2)
            rx_hold_req = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            l = draw_sample();
            r = draw_sample();
            offer_pair(l, r, 1'b0, '0, '0);
         end
      end

      settle_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d input pairs and %0d output pairs over %0d normal-rate and %0d",
               pairs_in, pairs_out, bursts_normal, bursts_half);
      $display("half-rate bursts, %0d clamped samples, one %0d-cycle output stall",
               clamped_samples, RX_HOLD);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", error_count);
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/xzr_pkg.sv
design/xzr_if.sv
design/xzr_mac_unit.sv
design/xa_zigzag_polyphase_resampler.sv
test/xa_zigzag_polyphase_resampler_tb.sv
